// ----- hdl/urk4_pkg.sv -----
`default_nettype none
package urk4_pkg;

  localparam int SINCOS_STAGES = 16;
  localparam int ATAN_STAGES = 24;
  localparam int NSTG = (SINCOS_STAGES > ATAN_STAGES) ? ATAN_STAGES : SINCOS_STAGES;

  // angle and vector datapath width (Q.30 with headroom)
  localparam int AW = 36;
  localparam int VW = 34;

  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [VW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [15:0] STEP_TIME_RESET = 16'd3277;
  localparam logic [0:0] REG_STEP_TIME = 1'b0;

  // increment divisor 6 * 2^29
  localparam logic [33:0] DIV_DEN = 34'd3221225472;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] speed;
    logic signed [15:0] turn_rate;
  } in_beat_t;

  typedef struct packed {
    logic signed [23:0] next_x;
    logic signed [23:0] next_y;
    logic signed [15:0] next_heading;
    logic               saturated;
  } out_beat_t;

  // payload carried beside the cordic rows
  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] next_heading;
    logic               hsat;
    logic signed [32:0] dtv;
  } side_t;

  // one cordic lane: angle residue, vector, fold sign
  typedef struct packed {
    logic signed [AW-1:0] z;
    logic signed [VW-1:0] cx;
    logic signed [VW-1:0] sy;
    logic                 neg;
  } lane_t;

  typedef struct packed {
    logic  vld;
    side_t side;
    lane_t [2:0] ln;
  } row_t;

  function automatic logic signed [AW-1:0] atan_q30(input int i);
    logic [31:0] t;
    unique case (i)
      0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
      3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
      6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
      9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
      12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
      15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
      18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
      21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
      default: t = 32'h0;
    endcase
    return $signed({4'b0, t});
  endfunction

endpackage
`default_nettype wire

// ----- hdl/urk4_cell.sv -----
`default_nettype none
// one cordic micro-rotation on three lanes, registered
module urk4_cell (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic [4:0]                shift,
  input  wire logic signed [urk4_pkg::AW-1:0] atan_c,
  input  wire urk4_pkg::row_t            row_in,
  output urk4_pkg::row_t                 row_out
);
  urk4_pkg::row_t row_r, row_nxt;

  always_comb begin
    row_nxt = row_in;
    for (int k = 0; k < 3; k++) begin
      if (!row_in.ln[k].z[urk4_pkg::AW-1]) begin
        row_nxt.ln[k].cx = row_in.ln[k].cx - (row_in.ln[k].sy >>> shift);
        row_nxt.ln[k].sy = row_in.ln[k].sy + (row_in.ln[k].cx >>> shift);
        row_nxt.ln[k].z  = row_in.ln[k].z - atan_c;
      end else begin
        row_nxt.ln[k].cx = row_in.ln[k].cx + (row_in.ln[k].sy >>> shift);
        row_nxt.ln[k].sy = row_in.ln[k].sy - (row_in.ln[k].cx >>> shift);
        row_nxt.ln[k].z  = row_in.ln[k].z + atan_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r.vld <= 1'b0;
    end else if (en) begin
      row_r.vld <= row_nxt.vld;
    end
    if (en) begin
      row_r.side <= row_nxt.side;
      row_r.ln   <= row_nxt.ln;
    end
  end

  assign row_out = row_r;
endmodule
`default_nettype wire

// ----- hdl/urk4_front.sv -----
`default_nettype none
// products, stage angles and range folding, two register stages
module urk4_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_in,
  input  wire urk4_pkg::in_beat_t   beat,
  input  wire logic [15:0]          step_time,
  output urk4_pkg::row_t            row_out
);
  logic               v1_r;
  logic signed [32:0] dw_r, dtv_r;
  logic signed [15:0] th_r;
  logic signed [23:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= vld_in;
    if (en) begin
      dw_r  <= $signed({1'b0, step_time}) * beat.turn_rate;
      dtv_r <= $signed({1'b0, step_time}) * beat.speed;
      th_r  <= beat.heading;
      px_r  <= beat.pos_x;
      py_r  <= beat.pos_y;
    end
  end

  urk4_pkg::row_t row_r, row_nxt;
  logic signed [urk4_pkg::AW-1:0] a [3];
  logic signed [urk4_pkg::AW-1:0] th0;
  logic signed [34:0] hsum;
  logic signed [18:0] hq;

  always_comb begin
    th0  = urk4_pkg::AW'(th_r) <<< 17;
    a[0] = th0;
    a[1] = th0 + urk4_pkg::AW'(dw_r);
    a[2] = th0 + (urk4_pkg::AW'(dw_r) <<< 1);
    row_nxt.vld = v1_r;
    for (int k = 0; k < 3; k++) begin
      logic signed [urk4_pkg::AW-1:0] t;
      logic ng;
      t = a[k];
      ng = 1'b0;
      if (t > urk4_pkg::PI_Q30) t = t - urk4_pkg::TWO_PI_Q30;
      if (t < -urk4_pkg::PI_Q30) t = t + urk4_pkg::TWO_PI_Q30;
      if (t > urk4_pkg::HALF_PI_Q30) begin
        t = t - urk4_pkg::PI_Q30; ng = 1'b1;
      end else if (t < -urk4_pkg::HALF_PI_Q30) begin
        t = t + urk4_pkg::PI_Q30; ng = 1'b1;
      end
      row_nxt.ln[k].z   = t;
      row_nxt.ln[k].cx  = urk4_pkg::GAIN_Q30;
      row_nxt.ln[k].sy  = '0;
      row_nxt.ln[k].neg = ng;
    end
    hsum = (35'(th_r) <<< 16) + 35'(dw_r) + 35'sd32768;
    hq   = hsum[34:16];
    row_nxt.side.pos_x = px_r;
    row_nxt.side.pos_y = py_r;
    row_nxt.side.dtv   = dtv_r;
    if (hq > 19'sd32767) begin
      row_nxt.side.next_heading = 16'sd32767; row_nxt.side.hsat = 1'b1;
    end else if (hq < -19'sd32768) begin
      row_nxt.side.next_heading = -16'sd32768; row_nxt.side.hsat = 1'b1;
    end else begin
      row_nxt.side.next_heading = hq[15:0]; row_nxt.side.hsat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) row_r.vld <= 1'b0;
    else if (en) row_r.vld <= row_nxt.vld;
    if (en) begin
      row_r.side <= row_nxt.side;
      row_r.ln   <= row_nxt.ln;
    end
  end

  assign row_out = row_r;
endmodule
`default_nettype wire

// ----- hdl/urk4_back.sv -----
`default_nettype none
// weighted sums, scaled increment, position update and clipping
module urk4_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire urk4_pkg::row_t    row_in,
  output logic                   vld_out,
  output urk4_pkg::out_beat_t    beat_out
);
  // stage a: sums rounded to q.16
  logic               va_r;
  urk4_pkg::side_t    sa_r;
  logic signed [24:0] s16x_r, s16y_r;
  logic signed [urk4_pkg::VW+3:0] c [3], s [3];
  logic signed [urk4_pkg::VW+3:0] sx, sy;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c[k] = row_in.ln[k].neg ? -(urk4_pkg::VW+4)'(row_in.ln[k].cx)
                              :  (urk4_pkg::VW+4)'(row_in.ln[k].cx);
      s[k] = row_in.ln[k].neg ? -(urk4_pkg::VW+4)'(row_in.ln[k].sy)
                              :  (urk4_pkg::VW+4)'(row_in.ln[k].sy);
    end
    sx = c[0] + (c[1] <<< 2) + c[2] + 38'sd8192;
    sy = s[0] + (s[1] <<< 2) + s[2] + 38'sd8192;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= row_in.vld;
    if (en) begin
      sa_r   <= row_in.side;
      s16x_r <= 25'(sx >>> 14);
      s16y_r <= 25'(sy >>> 14);
    end
  end

  // stage b: products
  logic               vb_r;
  urk4_pkg::side_t    sb_r;
  logic signed [57:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
    if (en) begin
      sb_r <= sa_r;
      px_r <= 58'(sa_r.dtv) * 58'(s16x_r);
      py_r <= 58'(sa_r.dtv) * 58'(s16y_r);
    end
  end

  // stage c: rounded magnitude, quotient by reciprocal
  // q = floor((m + den/2) / den), den = 3*2^30; quotient fits 28 bits
  logic               vc_r;
  urk4_pkg::side_t    sc_r;
  logic               nx_r, ny_r;
  logic [57:0]        mx_r, my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
    if (en) begin
      sc_r <= sb_r;
      nx_r <= px_r[57];
      ny_r <= py_r[57];
      mx_r <= (px_r[57] ? 58'(-px_r) : 58'(px_r)) + 58'(urk4_pkg::DIV_DEN >> 1);
      my_r <= (py_r[57] ? 58'(-py_r) : 58'(py_r)) + 58'(urk4_pkg::DIV_DEN >> 1);
    end
  end

  // high part for the divide by 3: t = m>>30 (<2^28); q0 = t/3 via table-free multiply in the next stage
  logic               vd_r;
  urk4_pkg::side_t    sd_r;
  logic               nxd_r, nyd_r;
  logic [27:0]        tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vc_r;
    if (en) begin
      sd_r  <= sc_r;
      nxd_r <= nx_r;
      nyd_r <= ny_r;
      tx_r  <= mx_r[57:30];
      ty_r  <= my_r[57:30];
    end
  end

  // q = floor(t/3) since low part < 2^30; t/3 = (t*0xAAAAAAB)>>29 exact for t<2^28
  logic               ve_r;
  urk4_pkg::side_t    se_r;
  logic               nxe_r, nye_r;
  logic [55:0]        qx_r, qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (en) ve_r <= vd_r;
    if (en) begin
      se_r  <= sd_r;
      nxe_r <= nxd_r;
      nye_r <= nyd_r;
      qx_r  <= 56'(tx_r) * 56'(28'hAAAAAAB);
      qy_r  <= 56'(ty_r) * 56'(28'hAAAAAAB);
    end
  end

  logic signed [29:0] ix, iy;
  logic signed [30:0] sumx, sumy;
  urk4_pkg::out_beat_t ob_nxt, ob_r;
  logic vo_r;
  logic cx_sat, cy_sat;

  always_comb begin
    ix = nxe_r ? -$signed({1'b0, qx_r[55:29]}) : $signed({1'b0, qx_r[55:29]});
    iy = nye_r ? -$signed({1'b0, qy_r[55:29]}) : $signed({1'b0, qy_r[55:29]});
    sumx = 31'(se_r.pos_x) + 31'(ix);
    sumy = 31'(se_r.pos_y) + 31'(iy);
    cx_sat = 1'b0;
    cy_sat = 1'b0;
    if (sumx > 31'sd8388607) begin
      ob_nxt.next_x = 24'sd8388607; cx_sat = 1'b1;
    end else if (sumx < -31'sd8388608) begin
      ob_nxt.next_x = -24'sd8388608; cx_sat = 1'b1;
    end else begin
      ob_nxt.next_x = sumx[23:0];
    end
    if (sumy > 31'sd8388607) begin
      ob_nxt.next_y = 24'sd8388607; cy_sat = 1'b1;
    end else if (sumy < -31'sd8388608) begin
      ob_nxt.next_y = -24'sd8388608; cy_sat = 1'b1;
    end else begin
      ob_nxt.next_y = sumy[23:0];
    end
    ob_nxt.next_heading = se_r.next_heading;
    ob_nxt.saturated    = cx_sat | cy_sat | se_r.hsat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= ve_r;
    if (en) ob_r <= ob_nxt;
  end

  assign vld_out  = vo_r;
  assign beat_out = ob_r;
endmodule
`default_nettype wire

// ----- hdl/unicycle_rk4_pose_step_top.sv -----
`default_nettype none
// channel | ports                              | beat
// in      | in_valid, in_stall, in_data       | pose and control
// out     | out_valid, out_stall, out_data    | new pose, clip flag
// cfg     | psel/penable/pwrite/paddr/pwdata  | step_time at 0x0
//
// one beat in per cycle while in_stall is low; the pipe runs through the front
// stages, the cordic cell chain (three lanes in each cell) and the divide tail.
// the whole pipe advances together; a result held by out_stall freezes it
// and shows as in_stall.
// rst_n clears every valid bit and loads step_time with 3277.
module unicycle_rk4_pose_step_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire urk4_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output urk4_pkg::out_beat_t      out_data,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [0:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  logic [15:0] step_time_r;
  logic en;

  // stall only when the output holds a beat nobody took
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= urk4_pkg::STEP_TIME_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == urk4_pkg::REG_STEP_TIME) begin
      step_time_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr == urk4_pkg::REG_STEP_TIME) ? {16'b0, step_time_r} : '0;

  urk4_pkg::row_t rows [urk4_pkg::NSTG+1];

  urk4_front u_front (
    .clk, .rst_n, .en,
    .vld_in   (in_valid),
    .beat     (in_data),
    .step_time(step_time_r),
    .row_out  (rows[0])
  );

  for (genvar g = 0; g < urk4_pkg::NSTG; g++) begin : g_cell
    urk4_cell u_cell (
      .clk, .rst_n, .en,
      .shift  (5'(g)),
      .atan_c (urk4_pkg::atan_q30(g)),
      .row_in (rows[g]),
      .row_out(rows[g+1])
    );
  end

  urk4_back u_back (
    .clk, .rst_n, .en,
    .row_in  (rows[urk4_pkg::NSTG]),
    .vld_out (out_valid),
    .beat_out(out_data)
  );

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("held result changed");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule
`default_nettype wire
